// File: hw/rtl/mgc_pkg.sv
// shared types and constants of the mouse gesture classifier
package mgc_pkg;

   // sequencer program counter width
   localparam int PC_W = 5;
   // multiplier operand limb, operand and product widths
   localparam int LIMB_W = 25;
   localparam int MUL_W = 26;
   localparam int PROD_W = 52;
   // release-time accumulator, covariance and scaled covariance widths
   localparam int ACC_W = 102;
   localparam int CXX_W = 46;
   localparam int SCL_W = 50;
   // axis limit times point count
   localparam int LIM_W = 18;
   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 10;
   // button byte with only the right button held
   localparam logic [7:0] BTN_RIGHT_ONLY = 8'd2;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_CLICK      = 3'd1,
      CMD_MINIMIZE   = 3'd2,
      CMD_SNAP_RIGHT = 3'd3,
      CMD_SNAP_LEFT  = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE       = 2'd0,
      CSR_MAX_POINTS   = 2'd1,
      CSR_CLICK_POINTS = 2'd2,
      CSR_AXIS_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        buttons;
      logic signed [7:0] move_x;
      logic signed [7:0] move_y;
      logic signed [7:0] move_wheel;
   } req_type;

   typedef struct packed {
      logic              forward;
      logic [7:0]        out_buttons;
      logic signed [7:0] out_x;
      logic signed [7:0] out_y;
      logic signed [7:0] out_wheel;
      cmd_type           command;
   } rsp_type;

   // multiplier operand sources
   typedef enum logic [4:0] {
      OPD_ZERO,
      OPD_N,
      OPD_SXX_LO,
      OPD_SXX_HI,
      OPD_SYY_LO,
      OPD_SYY_HI,
      OPD_SXY_LO,
      OPD_SXY_HI,
      OPD_SX,
      OPD_SY,
      OPD_PX,
      OPD_PY,
      OPD_AXIS,
      OPD_A0,
      OPD_A1,
      OPD_B0,
      OPD_B1,
      OPD_C0,
      OPD_C1
   } opd_type;

   typedef enum logic [1:0] {
      ACC_NOP,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // product shift in limbs before it reaches the accumulator
   typedef enum logic [1:0] {
      SH_0,
      SH_1,
      SH_2
   } shift_type;

   typedef enum logic [3:0] {
      WR_NONE,
      WR_POINT,
      WR_SXX,
      WR_SYY,
      WR_SXY,
      WR_CXX,
      WR_CYY,
      WR_CXY_LIM,
      WR_DECIDE,
      WR_FINAL
   } wr_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_GOTO,
      C_IF_PASS,
      C_IF_POINT,
      C_END
   } cond_type;

   typedef struct packed {
      opd_type         a_sel;
      opd_type         b_sel;
      acc_op_type      acc_op;
      shift_type       acc_sh;
      wr_type          wr;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // what the current report asks of the datapath
   typedef struct packed {
      logic point;
      logic classify;
      logic gest;
      logic rel;
   } kind_type;

   typedef struct packed {
      ucode_type word;
      kind_type  kind;
   } ctl_type;

   typedef struct packed {
      logic       holding;
      logic [7:0] count;
   } stat_type;

endpackage

// File: hw/rtl/mgc_sequencer.sv
// microcode sequencer: step counter, control store and conditional jumps
module mgc_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mgc_pkg::kind_type kind_new,
   input  logic              stall,
   output mgc_pkg::ctl_type  ctl,
   output logic              busy,
   output logic              emit
);
   import mgc_pkg::*;

   // program entry points
   localparam logic [PC_W-1:0] PC_DISPATCH = 5'd0;
   localparam logic [PC_W-1:0] PC_POINT    = 5'd23;
   localparam logic [PC_W-1:0] PC_EMIT     = 5'd28;

   function automatic ucode_type uw(input opd_type a, input opd_type b,
                                    input acc_op_type op, input shift_type sh,
                                    input wr_type wr, input cond_type cond,
                                    input logic [PC_W-1:0] target);
      ucode_type w;
      w.a_sel  = a;
      w.b_sel  = b;
      w.acc_op = op;
      w.acc_sh = sh;
      w.wr     = wr;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic ucode_type rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         // dispatch on the kind of report
         5'd0:  w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_NONE, C_IF_PASS, PC_EMIT);
         5'd1:  w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_NONE, C_IF_POINT, PC_POINT);
         // cxx = n*sum_xx - sum_x^2
         5'd2:  w = uw(OPD_N, OPD_SXX_LO, ACC_NOP, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd3:  w = uw(OPD_N, OPD_SXX_HI, ACC_LOAD, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd4:  w = uw(OPD_SX, OPD_SX, ACC_ADD, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         // cyy = n*sum_yy - sum_y^2
         5'd5:  w = uw(OPD_N, OPD_SYY_LO, ACC_SUB, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd6:  w = uw(OPD_N, OPD_SYY_HI, ACC_LOAD, SH_0, WR_CXX, C_NEXT, PC_DISPATCH);
         5'd7:  w = uw(OPD_SY, OPD_SY, ACC_ADD, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         // cxy = n*sum_xy - sum_x*sum_y
         5'd8:  w = uw(OPD_N, OPD_SXY_LO, ACC_SUB, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd9:  w = uw(OPD_N, OPD_SXY_HI, ACC_LOAD, SH_0, WR_CYY, C_NEXT, PC_DISPATCH);
         5'd10: w = uw(OPD_SX, OPD_SY, ACC_ADD, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         // axis limit times n
         5'd11: w = uw(OPD_AXIS, OPD_N, ACC_SUB, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd12: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_CXY_LIM, C_NEXT, PC_DISPATCH);
         // (10 cxy)^2 - (9 cxx)(9 cyy) over limb products
         5'd13: w = uw(OPD_A0, OPD_A0, ACC_NOP, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd14: w = uw(OPD_A0, OPD_A1, ACC_LOAD, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd15: w = uw(OPD_A1, OPD_A0, ACC_ADD, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd16: w = uw(OPD_A1, OPD_A1, ACC_ADD, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd17: w = uw(OPD_B0, OPD_C0, ACC_ADD, SH_2, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd18: w = uw(OPD_B0, OPD_C1, ACC_SUB, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd19: w = uw(OPD_B1, OPD_C0, ACC_SUB, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd20: w = uw(OPD_B1, OPD_C1, ACC_SUB, SH_1, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd21: w = uw(OPD_ZERO, OPD_ZERO, ACC_SUB, SH_2, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd22: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_DECIDE, C_GOTO, PC_EMIT);
         // add one track point and its squares
         5'd23: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_POINT, C_NEXT, PC_DISPATCH);
         5'd24: w = uw(OPD_PX, OPD_PX, ACC_NOP, SH_0, WR_NONE, C_NEXT, PC_DISPATCH);
         5'd25: w = uw(OPD_PY, OPD_PY, ACC_NOP, SH_0, WR_SXX, C_NEXT, PC_DISPATCH);
         5'd26: w = uw(OPD_PX, OPD_PY, ACC_NOP, SH_0, WR_SYY, C_NEXT, PC_DISPATCH);
         5'd27: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_SXY, C_NEXT, PC_DISPATCH);
         // hand the result over and settle the gesture state
         5'd28: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_FINAL, C_END, PC_DISPATCH);
         default: w = uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_NONE, C_END, PC_DISPATCH);
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            busy_ff, busy_in;
   kind_type        kind_ff, kind_in;
   ucode_type       word;

   assign word = rom(pc_ff);

   // next step
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      kind_in = kind_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = PC_DISPATCH;
            kind_in = kind_new;
         end
      end else begin
         unique case (word.cond)
            C_NEXT:     pc_in = pc_ff + 1'b1;
            C_GOTO:     pc_in = word.target;
            C_IF_PASS:  pc_in = (kind_ff.point || kind_ff.classify) ? pc_ff + 1'b1
                                                                    : word.target;
            C_IF_POINT: pc_in = kind_ff.point ? word.target : pc_ff + 1'b1;
            C_END: begin
               if (!stall) begin
                  busy_in = 1'b0;
               end
            end
            default:    busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_DISPATCH;
         busy_ff <= 1'b0;
         kind_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
         kind_ff <= kind_in;
      end
   end

   // control word to the datapath, quiet while idle
   assign ctl.word = busy_ff ? word
                             : uw(OPD_ZERO, OPD_ZERO, ACC_NOP, SH_0, WR_NONE, C_NEXT,
                                  PC_DISPATCH);
   assign ctl.kind = kind_ff;
   assign busy     = busy_ff;
   assign emit     = busy_ff && (word.cond == C_END) && !stall;

endmodule

// File: hw/rtl/mgc_datapath.sv
// gesture datapath: track state, shared multiplier, accumulator and line test
module mgc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mgc_pkg::ctl_type  ctl,
   input  logic signed [7:0] move_x,
   input  logic signed [7:0] move_y,
   input  logic [9:0]        axis_limit,
   output mgc_pkg::stat_type stat,
   output mgc_pkg::cmd_type  cmd
);
   import mgc_pkg::*;

   localparam int SLP_W = 24;

   // gesture state
   logic               holding_ff, holding_in;
   logic [7:0]         count_ff, count_in;
   logic signed [15:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [15:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [23:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [38:0]        sum_xx_ff, sum_xx_in, sum_yy_ff, sum_yy_in;
   logic signed [39:0] sum_xy_ff, sum_xy_in;

   // release-time working registers
   logic signed [PROD_W-1:0] pr_ff, pr_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [SCL_W-1:0]         cxx9_ff, cyy9_ff, cxy10_ff;
   logic [LIM_W-1:0]         lim_ff;
   cmd_type                  cmd_ff, cmd_in;

   logic signed [MUL_W-1:0]  a_opd, b_opd;
   logic signed [ACC_W-1:0]  pr_ext, pr_sh, acc_abs;
   logic [CXX_W-1:0]         cov, cov_mag;
   logic [SCL_W-1:0]         cov9, cov10;

   // multiplier operand select
   function automatic logic signed [MUL_W-1:0] pick(input opd_type s);
      logic signed [MUL_W-1:0] v;
      case (s)
         OPD_N:      v = {18'b0, count_ff};
         OPD_SXX_LO: v = {1'b0, sum_xx_ff[LIMB_W-1:0]};
         OPD_SXX_HI: v = {12'b0, sum_xx_ff[38:LIMB_W]};
         OPD_SYY_LO: v = {1'b0, sum_yy_ff[LIMB_W-1:0]};
         OPD_SYY_HI: v = {12'b0, sum_yy_ff[38:LIMB_W]};
         OPD_SXY_LO: v = {1'b0, sum_xy_ff[LIMB_W-1:0]};
         OPD_SXY_HI: v = {{11{sum_xy_ff[39]}}, sum_xy_ff[39:LIMB_W]};
         OPD_SX:     v = {{2{sum_x_ff[23]}}, sum_x_ff};
         OPD_SY:     v = {{2{sum_y_ff[23]}}, sum_y_ff};
         OPD_PX:     v = {{10{pos_x_ff[15]}}, pos_x_ff};
         OPD_PY:     v = {{10{pos_y_ff[15]}}, pos_y_ff};
         OPD_AXIS:   v = {16'b0, axis_limit};
         OPD_A0:     v = {1'b0, cxy10_ff[LIMB_W-1:0]};
         OPD_A1:     v = {1'b0, cxy10_ff[SCL_W-1:LIMB_W]};
         OPD_B0:     v = {1'b0, cxx9_ff[LIMB_W-1:0]};
         OPD_B1:     v = {1'b0, cxx9_ff[SCL_W-1:LIMB_W]};
         OPD_C0:     v = {1'b0, cyy9_ff[LIMB_W-1:0]};
         OPD_C1:     v = {1'b0, cyy9_ff[SCL_W-1:LIMB_W]};
         default:    v = '0;
      endcase
      return v;
   endfunction

   // shared multiplier, product registered
   always_comb begin
      a_opd = pick(ctl.word.a_sel);
      b_opd = pick(ctl.word.b_sel);
      pr_in = a_opd * b_opd;
   end

   // product aligned to its limb position
   assign pr_ext = ACC_W'(pr_ff);
   always_comb begin
      unique case (ctl.word.acc_sh)
         SH_1:    pr_sh = pr_ext <<< LIMB_W;
         SH_2:    pr_sh = pr_ext <<< (2 * LIMB_W);
         default: pr_sh = pr_ext;
      endcase
   end

   // accumulator
   always_comb begin
      unique case (ctl.word.acc_op)
         ACC_LOAD: acc_in = pr_sh;
         ACC_ADD:  acc_in = acc_ff + pr_sh;
         ACC_SUB:  acc_in = acc_ff - pr_sh;
         default:  acc_in = acc_ff;
      endcase
   end

   // covariance scaling: 9 cxx, 9 cyy, 10 |cxy|
   assign cov     = acc_ff[CXX_W-1:0];
   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign cov_mag = acc_abs[CXX_W-1:0];
   assign cov9    = (SCL_W'(cov) << 3) + SCL_W'(cov);
   assign cov10   = (SCL_W'(cov_mag) << 3) + (SCL_W'(cov_mag) << 1);

   // line test and slope classification
   logic [23:0]             abs_sx, abs_sy;
   logic                    line_hit;
   logic signed [16:0]      dx_raw, dy_raw, dx_nz;
   logic signed [SLP_W-1:0] dx_a, dy_a, dx3, dy10;
   logic                    is_min, is_snap;

   always_comb begin
      abs_sx   = sum_x_ff[23] ? 24'(-sum_x_ff) : 24'(sum_x_ff);
      abs_sy   = sum_y_ff[23] ? 24'(-sum_y_ff) : 24'(sum_y_ff);
      line_hit = (cxx9_ff == '0) || (cyy9_ff == '0)
                 || (!acc_ff[ACC_W-1] && (acc_ff != '0))
                 || (abs_sx < 24'(lim_ff)) || (abs_sy < 24'(lim_ff));
      dx_raw   = {pos_x_ff[15], pos_x_ff} - {first_x_ff[15], first_x_ff};
      dy_raw   = {pos_y_ff[15], pos_y_ff} - {first_y_ff[15], first_y_ff};
      dx_nz    = (dx_raw == '0) ? 17'sd1 : dx_raw;
      // fold a leftward run into the right half-plane
      if (dx_nz[16]) begin
         dx_a = -SLP_W'(dx_nz);
         dy_a = -SLP_W'(dy_raw);
      end else begin
         dx_a = SLP_W'(dx_nz);
         dy_a = SLP_W'(dy_raw);
      end
      dx3     = (dx_a <<< 1) + dx_a;
      dy10    = (dy_a <<< 3) + (dy_a <<< 1);
      is_min  = (dy10 < -dx3) && (dy_a > -dx3);
      is_snap = (dy_a > -dx3) && (dy_a < dx3);
      if (!line_hit) begin
         cmd_in = CMD_NONE;
      end else if (is_min) begin
         cmd_in = CMD_MINIMIZE;
      end else if (is_snap) begin
         cmd_in = (pos_x_ff > 16'sd0) ? CMD_SNAP_RIGHT : CMD_SNAP_LEFT;
      end else begin
         cmd_in = CMD_NONE;
      end
   end

   // gesture state updates
   logic signed [15:0] base_x, base_y, pt_x, pt_y;

   always_comb begin
      base_x     = (count_ff == '0) ? 16'sd0 : pos_x_ff;
      base_y     = (count_ff == '0) ? 16'sd0 : pos_y_ff;
      pt_x       = base_x + {{8{move_x[7]}}, move_x};
      pt_y       = base_y + {{8{move_y[7]}}, move_y};
      holding_in = holding_ff;
      count_in   = count_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      sum_xx_in  = sum_xx_ff;
      sum_yy_in  = sum_yy_ff;
      sum_xy_in  = sum_xy_ff;
      case (ctl.word.wr)
         WR_POINT: begin
            pos_x_in = pt_x;
            pos_y_in = pt_y;
            if (count_ff == '0) begin
               first_x_in = pt_x;
               first_y_in = pt_y;
            end
            sum_x_in = sum_x_ff + {{8{pt_x[15]}}, pt_x};
            sum_y_in = sum_y_ff + {{8{pt_y[15]}}, pt_y};
            count_in = count_ff + 1'b1;
         end
         WR_SXX: sum_xx_in = sum_xx_ff + pr_ff[38:0];
         WR_SYY: sum_yy_in = sum_yy_ff + pr_ff[38:0];
         WR_SXY: sum_xy_in = sum_xy_ff + pr_ff[39:0];
         WR_FINAL: begin
            if (ctl.kind.rel) begin
               holding_in = 1'b0;
               count_in   = '0;
               first_x_in = '0;
               first_y_in = '0;
               pos_x_in   = '0;
               pos_y_in   = '0;
               sum_x_in   = '0;
               sum_y_in   = '0;
               sum_xx_in  = '0;
               sum_yy_in  = '0;
               sum_xy_in  = '0;
            end else if (ctl.kind.gest) begin
               holding_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         count_ff   <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         sum_xx_ff  <= '0;
         sum_yy_ff  <= '0;
         sum_xy_ff  <= '0;
      end else begin
         holding_ff <= holding_in;
         count_ff   <= count_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
         sum_xx_ff  <= sum_xx_in;
         sum_yy_ff  <= sum_yy_in;
         sum_xy_ff  <= sum_xy_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      pr_ff  <= pr_in;
      acc_ff <= acc_in;
      if (ctl.word.wr == WR_CXX) begin
         cxx9_ff <= cov9;
      end
      if (ctl.word.wr == WR_CYY) begin
         cyy9_ff <= cov9;
      end
      if (ctl.word.wr == WR_CXY_LIM) begin
         cxy10_ff <= cov10;
         lim_ff   <= pr_ff[LIM_W-1:0];
      end
      if (ctl.word.wr == WR_DECIDE) begin
         cmd_ff <= cmd_in;
      end
   end

   assign stat.holding = holding_ff;
   assign stat.count   = count_ff;
   assign cmd          = cmd_ff;

endmodule

// File: hw/rtl/mouse_gesture_classifier_unit.sv
// top level of the mouse gesture classifier: handshakes, registers, result buffer
// steps: a passed report only emits, a tracked point adds its point first and a
//   classified release runs the line test; all steps run on one microcode pc
// intake: the next report waits until the previous result is registered; the
//   release-time products share a single 26x26 multiplier, one limb product a step
// reset: synchronous; registers return to their defaults and the gesture state
//   clears at once, with no clearing pass
module mouse_gesture_classifier_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mgc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mgc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mgc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mgc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mgc_pkg::*;

   // configuration registers
   logic       enable_ff, enable_in;
   logic [7:0] max_points_ff, max_points_in;
   logic [7:0] click_points_ff, click_points_in;
   logic [9:0] axis_limit_ff, axis_limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      enable_in       = enable_ff;
      max_points_in   = max_points_ff;
      click_points_in = click_points_ff;
      axis_limit_in   = axis_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:       enable_in       = csr_wdata[0];
            CSR_MAX_POINTS:   max_points_in   = csr_wdata[7:0];
            CSR_CLICK_POINTS: click_points_in = csr_wdata[7:0];
            CSR_AXIS_LIMIT:   axis_limit_in   = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b1;
         max_points_ff   <= 8'd200;
         click_points_ff <= 8'd5;
         axis_limit_ff   <= 10'd20;
      end else begin
         enable_ff       <= enable_in;
         max_points_ff   <= max_points_in;
         click_points_ff <= click_points_in;
         axis_limit_ff   <= axis_limit_in;
      end
   end

   ctl_type  ctl;
   stat_type stat;
   cmd_type  cmd;
   logic     busy, emit, stall, req_fire, is_right, is_click;
   kind_type kind_new;
   rsp_type  pend_ff, pend_in;
   req_type  req_ff;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;

   // sort the report against the current gesture state
   always_comb begin
      is_right          = (req_data.buttons == BTN_RIGHT_ONLY);
      kind_new.gest     = enable_ff && is_right;
      kind_new.rel      = enable_ff && !is_right && stat.holding;
      kind_new.point    = kind_new.gest && (stat.count < max_points_ff);
      is_click          = kind_new.rel
                          && ((stat.count == '0) || (stat.count <= click_points_ff));
      kind_new.classify = kind_new.rel && !is_click;
   end

   // result as known at transfer time
   always_comb begin
      pend_in.forward     = 1'b1;
      pend_in.out_buttons = req_data.buttons;
      pend_in.out_x       = req_data.move_x;
      pend_in.out_y       = req_data.move_y;
      pend_in.out_wheel   = req_data.move_wheel;
      pend_in.command     = CMD_NONE;
      if (kind_new.gest) begin
         pend_in.out_buttons = '0;
         if (!stat.holding) begin
            pend_in.forward   = 1'b0;
            pend_in.out_x     = '0;
            pend_in.out_y     = '0;
            pend_in.out_wheel = '0;
         end
      end else if (kind_new.rel) begin
         pend_in.forward = 1'b0;
         if (is_click) begin
            pend_in.out_buttons = BTN_RIGHT_ONLY;
            pend_in.command     = CMD_CLICK;
         end else begin
            pend_in.out_buttons = '0;
            pend_in.out_x       = '0;
            pend_in.out_y       = '0;
            pend_in.out_wheel   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_ff <= pend_in;
         req_ff  <= req_data;
      end
   end

   mgc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .kind_new (kind_new),
      .stall    (stall),
      .ctl      (ctl),
      .busy     (busy),
      .emit     (emit)
   );

   mgc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .move_x     (req_ff.move_x),
      .move_y     (req_ff.move_y),
      .axis_limit (axis_limit_ff),
      .stat       (stat),
      .cmd        (cmd)
   );

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign stall = rsp_valid_ff && !rsp_ready;

   always_comb begin
      rsp_valid_in = emit || stall;
      rsp_in       = pend_ff;
      if (ctl.kind.classify) begin
         rsp_in.command = cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a transfer starts a program that holds off the next report
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("report taken while the previous one is still in work");

   // a release leaves the gesture state cleared
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      emit && ctl.kind.rel |=> !stat.holding && (stat.count == '0))
      else $error("gesture state not cleared after release");

   // a tracked point leaves the gesture held
   a_point_holds: assert property (@(posedge clock) disable iff (reset)
      emit && ctl.kind.point |=> stat.holding && (stat.count != '0))
      else $error("tracked point did not leave the gesture held");

   // a classified release is swallowed and is not a click
   a_classify_result: assert property (@(posedge clock) disable iff (reset)
      emit && ctl.kind.classify |=> rsp_valid && !rsp_data.forward
                                    && (rsp_data.command != CMD_CLICK))
      else $error("classified release gave a wrong result shape");

endmodule

// File: tb/sv/mgc_checker.sv
// transfer monitor, gesture predictor and result comparator of the mouse gesture classifier
module mgc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  mgc_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  mgc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mgc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mgc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   import mgc_pkg::*;

   // register defaults after reset
   localparam logic [7:0] DEF_MAX_POINTS   = 8'd200;
   localparam logic [7:0] DEF_CLICK_POINTS = 8'd5;
   localparam logic [9:0] DEF_AXIS_LIMIT   = 10'd20;

   // shadow copy of the registers
   logic       cfg_enable;
   logic [7:0] cfg_max_points;
   logic [7:0] cfg_click_points;
   logic [9:0] cfg_axis_limit;

   // shadow copy of the gesture track
   logic               holding;
   logic [7:0]         npts;
   logic signed [15:0] first_x, first_y, pos_x, pos_y;
   logic signed [23:0] sum_x, sum_y;
   logic signed [38:0] sum_xx, sum_yy;
   logic signed [39:0] sum_xy;

   rsp_type expected_reports[$];

   function automatic void clear_track();
      holding = 1'b0;
      npts    = 8'd0;
      first_x = '0;
      first_y = '0;
      pos_x   = '0;
      pos_y   = '0;
      sum_x   = '0;
      sum_y   = '0;
      sum_xx  = '0;
      sum_yy  = '0;
      sum_xy  = '0;
   endfunction

   // line test on the accumulated track, then slope of the end-to-end chord
   function automatic cmd_type classify_track();
      longint     n, cxx, cyy, cxy, lim, ax, ay, dx, dy;
      logic [127:0] mag, lhs, rhs;
      logic       is_line;
      n   = longint'(npts);
      cxx = n * longint'(sum_xx) - longint'(sum_x) * longint'(sum_x);
      cyy = n * longint'(sum_yy) - longint'(sum_y) * longint'(sum_y);
      cxy = n * longint'(sum_xy) - longint'(sum_x) * longint'(sum_y);
      lim = longint'(cfg_axis_limit) * n;
      is_line = 1'b0;
      if (cxx <= 0 || cyy <= 0) begin
         is_line = 1'b1;
      end else begin
         mag = 128'(cxy < 0 ? -cxy : cxy);
         lhs = mag * mag * 128'd100;
         rhs = 128'(cxx) * 128'(cyy) * 128'd81;
         if (lhs > rhs) is_line = 1'b1;
      end
      ax = sum_x < 0 ? -longint'(sum_x) : longint'(sum_x);
      ay = sum_y < 0 ? -longint'(sum_y) : longint'(sum_y);
      if (ax < lim || ay < lim) is_line = 1'b1;
      if (!is_line) return CMD_NONE;
      // slope, normalized to a positive run
      dy = longint'(pos_y) - longint'(first_y);
      dx = longint'(pos_x) - longint'(first_x);
      if (dx == 0) dx = 1;
      if (dx < 0) begin
         dx = -dx;
         dy = -dy;
      end
      if (10 * dy < -3 * dx && dy > -3 * dx) return CMD_MINIMIZE;
      if (dy > -3 * dx && dy < 3 * dx) return (pos_x > 0) ? CMD_SNAP_RIGHT : CMD_SNAP_LEFT;
      return CMD_NONE;
   endfunction

   // expected result of one report, updating the shadow track
   task automatic predict_report(input req_type r, output rsp_type e);
      logic signed [15:0] base_x, base_y;
      e.forward     = 1'b1;
      e.out_buttons = r.buttons;
      e.out_x       = r.move_x;
      e.out_y       = r.move_y;
      e.out_wheel   = r.move_wheel;
      e.command     = CMD_NONE;
      if (cfg_enable) begin
         if (r.buttons == BTN_RIGHT_ONLY) begin
            // track point, ignored past capacity
            if (npts < cfg_max_points) begin
               base_x = (npts != 8'd0) ? pos_x : 16'sd0;
               base_y = (npts != 8'd0) ? pos_y : 16'sd0;
               pos_x  = base_x + r.move_x;
               pos_y  = base_y + r.move_y;
               if (npts == 8'd0) begin
                  first_x = pos_x;
                  first_y = pos_y;
               end
               sum_x  = sum_x + pos_x;
               sum_y  = sum_y + pos_y;
               sum_xx = sum_xx + pos_x * pos_x;
               sum_yy = sum_yy + pos_y * pos_y;
               sum_xy = sum_xy + pos_x * pos_y;
               npts   = npts + 8'd1;
            end
            e.out_buttons = 8'd0;
            // first report of a gesture is swallowed
            if (!holding) begin
               holding   = 1'b1;
               e.forward = 1'b0;
               e.out_x   = '0;
               e.out_y   = '0;
               e.out_wheel = '0;
            end
         end else if (holding) begin
            // release ends the gesture
            e.forward = 1'b0;
            if (npts == 8'd0 || npts <= cfg_click_points) begin
               e.out_buttons = BTN_RIGHT_ONLY;
               e.command     = CMD_CLICK;
            end else begin
               e.out_buttons = 8'd0;
               e.out_x       = '0;
               e.out_y       = '0;
               e.out_wheel   = '0;
               e.command     = classify_track();
            end
            clear_track();
         end
      end
   endtask

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      rsp_type exp_r;
      rsp_type next_r;
      if (reset) begin
         cfg_enable       = 1'b1;
         cfg_max_points   = DEF_MAX_POINTS;
         cfg_click_points = DEF_CLICK_POINTS;
         cfg_axis_limit   = DEF_AXIS_LIMIT;
         clear_track();
         expected_reports.delete();
         mismatch_count = 0;
      end else begin
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:       cfg_enable       = csr_wdata[0];
               CSR_MAX_POINTS:   cfg_max_points   = csr_wdata[7:0];
               CSR_CLICK_POINTS: cfg_click_points = csr_wdata[7:0];
               CSR_AXIS_LIMIT:   cfg_axis_limit   = csr_wdata[9:0];
               default: ;
            endcase
         end
         // result transfer against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result transfer with no expected result pending");
               mismatch_count++;
            end else begin
               exp_r = expected_reports.pop_front();
               check_field("forward", int'(exp_r.forward), int'(rsp_data.forward));
               check_field("out_buttons", int'(exp_r.out_buttons), int'(rsp_data.out_buttons));
               check_field("out_x", int'(exp_r.out_x), int'(rsp_data.out_x));
               check_field("out_y", int'(exp_r.out_y), int'(rsp_data.out_y));
               check_field("out_wheel", int'(exp_r.out_wheel), int'(rsp_data.out_wheel));
               check_field("command", int'(exp_r.command), int'(rsp_data.command));
            end
         end
         // report transfer
         if (req_valid && req_ready) begin
            predict_report(req_data, next_r);
            expected_reports.push_back(next_r);
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// stimulus, clocking and verdict for the mouse gesture classifier
module tb_top;
   import mgc_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_count;

   // traffic shaping knobs
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;
   int cfg_max_points = 200;

   mouse_gesture_classifier_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mgc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #6000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic signed [7:0] clamp8(input int v);
      if (v > 127) return 8'sd127;
      if (v < -128) return -8'sd128;
      return v[7:0];
   endfunction

   function automatic req_type make_req(input logic [7:0] b, input int x, input int y,
                                        input int w);
      req_type r;
      r.buttons    = b;
      r.move_x     = clamp8(x);
      r.move_y     = clamp8(y);
      r.move_wheel = clamp8(w);
      return r;
   endfunction

   function automatic int jitter(input int j);
      return int'($urandom_range(2 * j)) - j;
   endfunction

   // one report transfer; valid is left high, the next call or a drain lowers it
   task automatic send_report(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // right-button track of len points along a step vector
   task automatic send_track(input int len, input int vx, input int vy, input int j);
      for (int i = 0; i < len; i++) begin
         send_report(make_req(BTN_RIGHT_ONLY, vx + jitter(j), vy + jitter(j), jitter(128)));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // all four registers, written with junk in the unused upper bits
   task automatic configure(input logic en, input logic [7:0] maxp, input logic [7:0] clkp,
                            input logic [9:0] axis);
      drain();
      write_reg(CSR_ENABLE, {9'($urandom), en});
      write_reg(CSR_MAX_POINTS, {2'($urandom), maxp});
      write_reg(CSR_CLICK_POINTS, {2'($urandom), clkp});
      write_reg(CSR_AXIS_LIMIT, axis);
      csr_valid <= 1'b0;
      cfg_max_points = maxp;
   endtask

   // mostly complete gestures with random shape, the rest loose reports
   task automatic run_random(input int count);
      int         sent;
      int         len;
      int         vx, vy, j, sgn;
      logic [7:0] b;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 75) begin
            case ($urandom_range(99) / 35)
               0: len = $urandom_range(7);
               1: len = $urandom_range(8, 30);
               default: len = (cfg_max_points < 60) ? cfg_max_points + $urandom_range(1, 6)
                                                    : $urandom_range(31, 70);
            endcase
            sgn = $urandom_range(1) ? 1 : -1;
            j   = 1;
            case ($urandom_range(5))
               0: begin vx = $urandom_range(3, 20);  vy = jitter(2); end
               1: begin vx = -$urandom_range(3, 20); vy = jitter(2); end
               2: begin vx = $urandom_range(5, 15);  vy = -vx * sgn; end
               3: begin vx = 0; vy = sgn * $urandom_range(5, 20); end
               4: begin vx = 0; vy = 0; j = 127; end
               default: begin vx = sgn * 127; vy = -sgn * 120; j = 8; end
            endcase
            send_track(len, vx, vy, j);
            // release report
            b = ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom);
            if (b == BTN_RIGHT_ONLY) b = 8'd0;
            send_report(make_req(b, jitter(128), jitter(128), jitter(128)));
            sent += len + 1;
         end else begin
            b = ($urandom_range(99) < 20) ? BTN_RIGHT_ONLY : 8'($urandom);
            send_report(make_req(b, jitter(128), jitter(128), jitter(128)));
            sent++;
         end
      end
   endtask

   // main sequence
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ENABLE;
      csr_wdata = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pass-through extremes, click, and the three line commands
      send_report(make_req(8'hFF, 127, -128, 127));
      send_track(3, 4, -2, 0);
      send_report(make_req(8'h00, -128, 127, -128));
      send_track(6, 10, 0, 0);
      send_report(make_req(8'h00, 0, 0, 0));
      send_track(6, -10, 0, 0);
      send_report(make_req(8'h01, 5, 5, 5));
      send_track(6, 10, -10, 0);
      send_report(make_req(8'h80, 0, 0, 0));

      // defaults, no idling
      run_random(80);

      // gestures disabled, sender idling
      send_idle_pct  = 62;
      configure(1'b0, 8'd200, 8'd5, 10'd20);
      run_random(40);

      // widest limits, receiver stalling
      send_idle_pct  = 0;
      recv_stall_pct = 62;
      configure(1'b1, 8'd255, 8'd0, 10'd1023);
      run_random(100);

      // small capacity, both idling
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      configure(1'b1, 8'd6, 8'd2, 10'd0);
      run_random(80);

      // empty gestures, no idling
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure(1'b1, 8'd0, 8'd255, 10'd20);
      run_random(30);

      // receiver holds off while the sender keeps offering
      configure(1'b1, 8'd200, 8'd5, 10'd20);
      hold_cycles = 300;
      run_random(100);

      // random settings, both idling
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      configure(1'b1, 8'($urandom_range(6, 60)), 8'($urandom_range(10)),
                10'($urandom_range(100)));
      run_random(100);

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
